// File: hdl/nsr_pkg.sv
package nsr_pkg;

  localparam int DEF_STATES  = 16;
  localparam int DEF_LETTERS = 8;

  localparam int OP_W  = 2;
  localparam int IDX_W = 4;
  localparam int LET_W = 3;
  localparam int SET_W = 16;
  localparam int CFG_W = 16;
  localparam int REG_W = 1;

  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_START = 2'd1;
  localparam logic [OP_W-1:0] OP_STEP  = 2'd2;

  localparam logic [REG_W-1:0] REG_INITIAL = 1'b0;
  localparam logic [REG_W-1:0] REG_FINAL   = 1'b1;

  // queue depth must stay a power of two (pointers wrap)
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;

  localparam int KIND_W = 3;

  typedef enum logic [KIND_W-1:0] {
    K_LOAD,
    K_START,
    K_STEP,
    K_EMPTY,
    K_HOLD
  } kind_t;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_RUN,
    B_DRAIN,
    B_DONE
  } back_state_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// File: hdl/nsr_front.sv
module nsr_front #(
  parameter int STATES  = nsr_pkg::DEF_STATES,
  parameter int LETTERS = nsr_pkg::DEF_LETTERS,
  parameter int SW      = $clog2(STATES),
  parameter int LW      = $clog2(LETTERS),
  parameter int W       = nsr_pkg::KIND_W + SW + LW + STATES
) (
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [nsr_pkg::OP_W-1:0]   operation,
  input  logic [nsr_pkg::IDX_W-1:0]  state_index,
  input  logic [nsr_pkg::LET_W-1:0]  letter,
  input  logic [nsr_pkg::SET_W-1:0]  next_set,
  input  logic                       busy,
  input  nsr_pkg::q_status_t         q_status,
  output logic                       push,
  output logic [W-1:0]               cmd
);
  import nsr_pkg::*;

  kind_t kind;
  logic  idx_ok;
  logic  let_ok;

  assign idx_ok = int'(state_index) < STATES;
  assign let_ok = int'(letter) < LETTERS;

  always_comb begin
    case (operation)
      OP_LOAD:  kind = (idx_ok && let_ok) ? K_LOAD : K_HOLD;
      OP_START: kind = K_START;
      OP_STEP:  kind = let_ok ? K_STEP : K_EMPTY;
      default:  kind = K_HOLD;
    endcase
  end

  assign in_stall = q_status.full || busy;
  assign push     = in_valid && !in_stall;
  assign cmd      = {kind, SW'(state_index), LW'(letter), STATES'(next_set)};

endmodule

// File: hdl/nsr_queue.sv
module nsr_queue #(
  parameter int W = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic [W-1:0]       wdata,
  input  logic               pop,
  output logic [W-1:0]       head,
  output nsr_pkg::q_status_t q_status
);
  import nsr_pkg::*;

  logic [W-1:0]         slots [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr;
  logic [Q_PTR_W-1:0]   rd_ptr;
  logic [Q_PTR_W:0]     count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wdata;
  end

  assign head           = slots[rd_ptr];
  assign q_status.full  = count == (Q_PTR_W + 1)'(Q_DEPTH);
  assign q_status.empty = count == '0;

  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    q_status.full |-> !push) else $error("push into full queue");
  a_no_underrun: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_status.empty) else $error("pop from empty queue");

endmodule

// File: hdl/nsr_back.sv
module nsr_back #(
  parameter int STATES  = nsr_pkg::DEF_STATES,
  parameter int LETTERS = nsr_pkg::DEF_LETTERS,
  parameter int SW      = $clog2(STATES),
  parameter int LW      = $clog2(LETTERS),
  parameter int W       = nsr_pkg::KIND_W + SW + LW + STATES
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [W-1:0]               head,
  input  nsr_pkg::q_status_t         q_status,
  output logic                       pop,
  output logic                       busy,
  input  logic [nsr_pkg::CFG_W-1:0]  initial_set,
  input  logic [nsr_pkg::CFG_W-1:0]  final_set,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [nsr_pkg::SET_W-1:0]  active_set,
  output logic                       accepted
);
  import nsr_pkg::*;

  localparam int AW    = SW + LW;
  localparam int DEPTH = STATES << LW;

  back_state_t state;
  back_state_t state_next;

  kind_t             h_kind;
  logic [SW-1:0]     h_state;
  logic [LW-1:0]     h_letter;
  logic [STATES-1:0] h_mask;

  logic [STATES-1:0] mem [DEPTH];
  logic [AW-1:0]     clr_addr;
  logic [SW-1:0]     cnt;
  logic [LW-1:0]     cur_letter;
  logic [STATES-1:0] acc;
  logic [STATES-1:0] active;
  logic              rd_pend;
  logic              rd_bit;
  logic [STATES-1:0] rd_data;

  logic              out_free;
  logic              mem_we;
  logic [AW-1:0]     wr_addr;
  logic [STATES-1:0] wr_data;
  logic [AW-1:0]     rd_addr;
  logic              emit;
  logic [STATES-1:0] active_next;
  logic              last;

  assign h_kind   = kind_t'(head[W-1 -: KIND_W]);
  assign h_state  = head[LW+STATES +: SW];
  assign h_letter = head[STATES +: LW];
  assign h_mask   = head[STATES-1:0];

  assign out_free = !out_valid || !out_stall;
  assign last     = cnt == SW'(STATES - 1);
  assign busy     = state == B_CLEAR;

  always_comb begin
    state_next = state;
    case (state)
      B_CLEAR: if (clr_addr == AW'(DEPTH - 1)) state_next = B_IDLE;
      B_IDLE:  if (pop && h_kind == K_STEP) state_next = B_RUN;
      B_RUN:   if (last) state_next = B_DRAIN;
      B_DRAIN: state_next = B_DONE;
      B_DONE:  if (out_free) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    pop         = 1'b0;
    mem_we      = 1'b0;
    wr_addr     = {h_state, h_letter};
    wr_data     = h_mask;
    emit        = 1'b0;
    active_next = active;
    case (state)
      B_CLEAR: begin
        mem_we  = 1'b1;
        wr_addr = clr_addr;
        wr_data = '0;
      end
      B_IDLE: begin
        pop = !q_status.empty && out_free;
        if (pop) begin
          case (h_kind)
            K_LOAD:  begin mem_we = 1'b1; emit = 1'b1; end
            K_START: begin active_next = STATES'(initial_set); emit = 1'b1; end
            K_EMPTY: begin active_next = '0; emit = 1'b1; end
            K_STEP:  emit = 1'b0;
            default: emit = 1'b1;
          endcase
        end
      end
      B_DONE: begin
        if (out_free) begin
          active_next = acc;
          emit        = 1'b1;
        end
      end
      default: emit = 1'b0;
    endcase
  end

  assign rd_addr = {cnt, cur_letter};

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_CLEAR;
      clr_addr  <= '0;
      active    <= '0;
      out_valid <= 1'b0;
      rd_pend   <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= state == B_RUN;
      if (state == B_CLEAR) clr_addr <= clr_addr + 1'b1;
      active <= active_next;
      if (emit) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    rd_bit <= active[cnt];
    if (state == B_IDLE && pop && h_kind == K_STEP) begin
      cnt        <= '0;
      cur_letter <= h_letter;
      acc        <= '0;
    end else begin
      if (state == B_RUN) cnt <= cnt + 1'b1;
      if (rd_pend && rd_bit) acc <= acc | rd_data;
    end
    if (emit) begin
      active_set <= SET_W'(active_next);
      accepted   <= |(SET_W'(active_next) & final_set);
    end
  end

  a_quiet_clear: assert property (@(posedge clk) disable iff (rst)
    state == B_CLEAR |-> !out_valid && !pop) else $error("activity during clear");
  a_read_pend: assert property (@(posedge clk) disable iff (rst)
    state == B_RUN |=> rd_pend) else $error("table read lost");
  a_hold_out: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> !emit) else $error("result overwritten");

endmodule

// File: hdl/nfa_state_set_runner.sv
// channel  | handshake           | word
// in       | in_valid / in_stall | operation, state_index, letter, next_set
// out      | out_valid/out_stall | active_set, accepted
// config   | write_enable        | reg_index, write_data
//
// Letter word: one table read per state in the back end (none if letter >= LETTERS).
// Load, start and other words: handled straight from the idle state in the back end.
// After reset all (STATES << clog2(LETTERS)) table entries, 128 by default, are zeroed;
// in_stall is high meanwhile.
// A two-word queue lets the input accept, until full, while a result waits on out_stall.
module nfa_state_set_runner #(
  parameter int STATES  = nsr_pkg::DEF_STATES,
  parameter int LETTERS = nsr_pkg::DEF_LETTERS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       write_enable,
  input  logic [nsr_pkg::REG_W-1:0]  reg_index,
  input  logic [nsr_pkg::CFG_W-1:0]  write_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [nsr_pkg::OP_W-1:0]   operation,
  input  logic [nsr_pkg::IDX_W-1:0]  state_index,
  input  logic [nsr_pkg::LET_W-1:0]  letter,
  input  logic [nsr_pkg::SET_W-1:0]  next_set,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [nsr_pkg::SET_W-1:0]  active_set,
  output logic                       accepted
);
  import nsr_pkg::*;

  localparam int SW = $clog2(STATES);
  localparam int LW = $clog2(LETTERS);
  localparam int W  = KIND_W + SW + LW + STATES;

  logic [CFG_W-1:0] initial_set;
  logic [CFG_W-1:0] final_set;
  logic             push;
  logic             pop;
  logic             busy;
  logic [W-1:0]     cmd;
  logic [W-1:0]     head;
  q_status_t        q_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      initial_set <= '0;
      final_set   <= '0;
    end else if (write_enable) begin
      case (reg_index)
        REG_INITIAL: initial_set <= write_data;
        REG_FINAL:   final_set   <= write_data;
        default:     initial_set <= initial_set;
      endcase
    end
  end

  nsr_front #(.STATES(STATES), .LETTERS(LETTERS), .SW(SW), .LW(LW), .W(W)) u_front (
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .operation   (operation),
    .state_index (state_index),
    .letter      (letter),
    .next_set    (next_set),
    .busy        (busy),
    .q_status    (q_status),
    .push        (push),
    .cmd         (cmd)
  );

  nsr_queue #(.W(W)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wdata    (cmd),
    .pop      (pop),
    .head     (head),
    .q_status (q_status)
  );

  nsr_back #(.STATES(STATES), .LETTERS(LETTERS), .SW(SW), .LW(LW), .W(W)) u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .q_status    (q_status),
    .pop         (pop),
    .busy        (busy),
    .initial_set (initial_set),
    .final_set   (final_set),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .active_set  (active_set),
    .accepted    (accepted)
  );

endmodule
